// ===== rtl/core/btm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btm_pkg
// Shared types and constants for the branch tag manager.
// ----------------------------------------------------------------------------
package btm_pkg;

    localparam int DEF_TAG_COUNT = 16;
    localparam int TAG_IN_W      = 4;
    localparam int CUR_TAG_W     = 4;
    localparam int KILL_W        = 16;
    localparam int IN_DATA_W     = 8;
    localparam int IN_USER_W     = 2;
    localparam int OUT_DATA_W    = 24;

    localparam logic [1:0] REQ_ALLOC  = 2'd0;
    localparam logic [1:0] REQ_MISP   = 2'd1;
    localparam logic [1:0] REQ_COMMIT = 2'd2;
    localparam logic [1:0] REQ_FLUSH  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PRIME,
        ST_WALK
    } btm_state_t;

endpackage

// ===== rtl/core/btm_ring_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btm_ring_mem
// Allocation-order ring: one write port, one registered read port.
// Entry zero reads as zero after reset or clear until it is written.
// ----------------------------------------------------------------------------
module btm_ring_mem
    import btm_pkg::*;
#(
    parameter int TAG_COUNT = DEF_TAG_COUNT,
    parameter int TW        = $clog2(TAG_COUNT)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clr0,
    input  logic          wr_en,
    input  logic [TW-1:0] wr_addr,
    input  logic [TW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [TW-1:0] rd_addr,
    output logic [TW-1:0] rd_data
);

    logic [TW-1:0] mem [TAG_COUNT];
    logic [TW-1:0] rd_data_reg;
    logic          rd_zero_reg;
    logic          zero_hold_reg;
    logic          zero_hold_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_zero_reg <= zero_hold_reg && (rd_addr == '0);
        end
    end

    always_comb
    begin
        zero_hold_next = zero_hold_reg;
        if (clr0)
        begin
            zero_hold_next = 1'b1;
        end
        else if (wr_en && (wr_addr == '0))
        begin
            zero_hold_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_hold_reg <= 1'b1;
        end
        else
        begin
            zero_hold_reg <= zero_hold_next;
        end
    end

    assign rd_data = rd_zero_reg ? '0 : rd_data_reg;

endmodule

// ===== rtl/core/btm_lowest_free.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btm_lowest_free
// Finds the lowest set bit of the free map: isolate with x & -x, then encode.
// ----------------------------------------------------------------------------
module btm_lowest_free
    import btm_pkg::*;
#(
    parameter int TAG_COUNT = DEF_TAG_COUNT,
    parameter int TW        = $clog2(TAG_COUNT)
)
(
    input  logic [TAG_COUNT-1:0] free_map,
    output logic                 found,
    output logic [TW-1:0]        idx
);

    logic [TAG_COUNT-1:0] onehot;

    assign onehot = free_map & (~free_map + TAG_COUNT'(1));
    assign found  = |free_map;

    always_comb
    begin
        idx = '0;
        for (int b = 0; b < TW; b++)
        begin
            for (int i = 0; i < TAG_COUNT; i++)
            begin
                if (onehot[i] && (((i >> b) & 1) == 1))
                begin
                    idx[b] = 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/core/branch_tag_manager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// branch_tag_manager
// Speculative branch tag allocator with mispredict kill mask.
// ----------------------------------------------------------------------------
// One request at a time. Allocate, commit and flush pass through accept and
// execute; a mispredict passes through accept, execute, prime and a walk of
// 1 to TAG_COUNT ring entries, reading the order ring through its single
// registered read port, one entry per cycle. A finished result sits
// in the output register; the next request is accepted meanwhile and
// completes only once that result is taken. No clearing pass after reset.
// ----------------------------------------------------------------------------
module branch_tag_manager
    import btm_pkg::*;
#(
    parameter int TAG_COUNT = DEF_TAG_COUNT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // [3:0] tag_in, [7:4] zero
    input  logic [IN_USER_W-1:0]  s_tuser,  // [1:0] req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata   // [3:0] current_tag, [4] alloc_ok,
                                            // [20:5] kill_mask, [21] not_found,
                                            // [23:22] zero
);

    localparam int TW = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;
    localparam int CW = (TW > TAG_IN_W) ? TW : TAG_IN_W;

    function automatic logic [TW-1:0] ring_dec(input logic [TW-1:0] p);
        ring_dec = (p == '0) ? TW'(TAG_COUNT - 1) : p - TW'(1);
    endfunction

    function automatic logic [TW-1:0] ring_inc(input logic [TW-1:0] p);
        ring_inc = (p == TW'(TAG_COUNT - 1)) ? '0 : p + TW'(1);
    endfunction

    function automatic logic [TAG_COUNT-1:0] tag_bit(input logic [TW-1:0] t);
        for (int i = 0; i < TAG_COUNT; i++)
        begin
            tag_bit[i] = (CW'(t) == CW'(i));
        end
    endfunction

    function automatic logic [TAG_COUNT-1:0] commit_bit(input logic [TAG_IN_W-1:0] t);
        for (int i = 0; i < TAG_COUNT; i++)
        begin
            commit_bit[i] = (CW'(t) == CW'(i));
        end
    endfunction

    function automatic logic [KILL_W-1:0] kill_bit(input logic [TW-1:0] t);
        for (int i = 0; i < KILL_W; i++)
        begin
            kill_bit[i] = (CW'(t) == CW'(i));
        end
    endfunction

    btm_state_t            state_reg, state_next;
    logic [1:0]            req_reg, req_next;
    logic [TAG_IN_W-1:0]   tag_reg, tag_next;
    logic [TAG_COUNT-1:0]  free_reg, free_next;
    logic [TW-1:0]         live_reg, live_next;
    logic [TW-1:0]         ptr_reg, ptr_next;
    logic [TW-1:0]         cur_reg, cur_next;
    logic [TW-1:0]         cur_val_reg, cur_val_next;
    logic [TW-1:0]         cnt_reg, cnt_next;
    logic [KILL_W-1:0]     kill_reg, kill_next;
    logic [TAG_COUNT-1:0]  freed_reg, freed_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic                  out_free;
    logic                  walk_match;
    logic                  walk_last;
    logic                  walk_done;
    logic [KILL_W-1:0]     walk_kill;
    logic                  lf_found;
    logic [TW-1:0]         lf_idx;
    logic                  ring_clr0;
    logic                  ring_wr_en;
    logic                  ring_rd_en;
    logic [TW-1:0]         ring_rd_addr;
    logic [TW-1:0]         ring_rd_data;
    logic [TAG_COUNT-1:0]  reset_free;

    btm_lowest_free #(
        .TAG_COUNT (TAG_COUNT),
        .TW        (TW)
    ) u_lowest_free (
        .free_map (free_reg),
        .found    (lf_found),
        .idx      (lf_idx)
    );

    btm_ring_mem #(
        .TAG_COUNT (TAG_COUNT),
        .TW        (TW)
    ) u_ring_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr0    (ring_clr0),
        .wr_en   (ring_wr_en),
        .wr_addr (ptr_reg),
        .wr_data (lf_idx),
        .rd_en   (ring_rd_en),
        .rd_addr (ring_rd_addr),
        .rd_data (ring_rd_data)
    );

    assign reset_free = ~TAG_COUNT'(1);
    assign out_free   = !out_valid_reg || m_tready;
    assign walk_match = (CW'(ring_rd_data) == CW'(tag_reg));
    assign walk_last  = (cnt_reg == TW'(TAG_COUNT - 1));
    assign walk_done  = walk_match || walk_last;
    assign walk_kill  = kill_reg | kill_bit(cur_val_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (req_reg == REQ_MISP)
                begin
                    state_next = ST_PRIME;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PRIME:
            begin
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (walk_done && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        req_next       = req_reg;
        tag_next       = tag_reg;
        free_next      = free_reg;
        live_next      = live_reg;
        ptr_next       = ptr_reg;
        cur_next       = cur_reg;
        cur_val_next   = cur_val_reg;
        cnt_next       = cnt_reg;
        kill_next      = kill_reg;
        freed_next     = freed_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        ring_clr0      = 1'b0;
        ring_wr_en     = 1'b0;
        ring_rd_en     = 1'b0;
        ring_rd_addr   = cur_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next = s_tuser;
                    tag_next = s_tdata[TAG_IN_W-1:0];
                end
            end
            ST_EXEC:
            begin
                if (req_reg == REQ_MISP)
                begin
                    cur_next     = ring_dec(ptr_reg);
                    cnt_next     = '0;
                    kill_next    = '0;
                    freed_next   = '0;
                    ring_rd_en   = 1'b1;
                    ring_rd_addr = ring_dec(ptr_reg);
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next[CUR_TAG_W-1:0] = CUR_TAG_W'(live_reg);
                    unique case (req_reg)
                        REQ_ALLOC:
                        begin
                            if (lf_found)
                            begin
                                live_next  = lf_idx;
                                free_next  = free_reg & ~tag_bit(lf_idx);
                                ring_wr_en = 1'b1;
                                ptr_next   = ring_inc(ptr_reg);
                                out_data_next[CUR_TAG_W-1:0] = CUR_TAG_W'(lf_idx);
                                out_data_next[CUR_TAG_W]     = 1'b1;
                            end
                        end
                        REQ_COMMIT:
                        begin
                            free_next = free_reg | commit_bit(tag_reg);
                        end
                        REQ_FLUSH:
                        begin
                            free_next = reset_free;
                            live_next = '0;
                            ptr_next  = TW'(1);
                            ring_clr0 = 1'b1;
                            out_data_next[CUR_TAG_W-1:0] = '0;
                        end
                        default:
                        begin
                            out_data_next = out_data_reg;
                        end
                    endcase
                end
            end
            ST_PRIME:
            begin
                cur_val_next = ring_rd_data;
                ring_rd_en   = 1'b1;
                ring_rd_addr = ring_dec(cur_reg);
            end
            ST_WALK:
            begin
                if (walk_done)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '0;
                        out_data_next[CUR_TAG_W-1:0] = CUR_TAG_W'(live_reg);
                        out_data_next[CUR_TAG_W+KILL_W:CUR_TAG_W+1] = walk_kill;
                        out_data_next[CUR_TAG_W+KILL_W+1] = !walk_match;
                        if (walk_match)
                        begin
                            free_next = free_reg | freed_reg;
                            live_next = cur_val_reg;
                            ptr_next  = ring_inc(cur_reg);
                            out_data_next[CUR_TAG_W-1:0] = CUR_TAG_W'(cur_val_reg);
                        end
                    end
                end
                else
                begin
                    kill_next    = walk_kill;
                    freed_next   = freed_reg | tag_bit(cur_val_reg);
                    cnt_next     = cnt_reg + TW'(1);
                    cur_next     = ring_dec(cur_reg);
                    cur_val_next = ring_rd_data;
                    ring_rd_en   = 1'b1;
                    ring_rd_addr = ring_dec(ring_dec(cur_reg));
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            free_reg      <= ~TAG_COUNT'(1);
            live_reg      <= '0;
            ptr_reg       <= TW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_reg      <= free_next;
            live_reg      <= live_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        tag_reg      <= tag_next;
        cur_reg      <= cur_next;
        cur_val_reg  <= cur_val_next;
        cnt_reg      <= cnt_next;
        kill_reg     <= kill_next;
        freed_reg    <= freed_next;
        out_data_reg <= out_data_next;
    end

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[CUR_TAG_W] && m_tdata[CUR_TAG_W+KILL_W+1]))
        else $error("alloc_ok and not_found both set");

    a_live_not_free: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[CUR_TAG_W]) |-> ((free_reg & tag_bit(live_reg)) == '0))
        else $error("allocated tag still marked free");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |->
            ($past(state_reg) == ST_EXEC || $past(state_reg) == ST_WALK))
        else $error("result produced outside execute or walk");

    a_alloc_no_kill: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[CUR_TAG_W]) |->
            (m_tdata[CUR_TAG_W+KILL_W:CUR_TAG_W+1] == '0))
        else $error("kill mask set on allocate");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the branch tag manager. A directed table walks
// reset, ring fill, tag exhaustion, found and unmatched mispredicts, commit
// and flush. Random request sequences follow. Every transfer is checked
// against the row's typed result or an in-bench tracker of free tags,
// allocation ring and live tag. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top
    import btm_pkg::*;
();

    localparam int NTAGS      = DEF_TAG_COUNT;
    localparam int RAND_ITEMS = 1825;
    localparam int LIMIT      = 600000;
    localparam int DRAIN      = 40;

    typedef struct packed {
        logic            not_found;
        logic [KILL_W-1:0] kill_mask;
        logic            alloc_ok;
        logic [3:0]      cur_tag;
    } tag_result_t;

    typedef struct {
        logic [1:0]  req;
        logic [3:0]  tag;
        bit          typed;
        tag_result_t res;
    } tag_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // tracker state
    logic [NTAGS-1:0] free_tags;
    logic [3:0]       alloc_ring [NTAGS];
    logic [NTAGS-1:0] ring_valid;
    logic [3:0]       live;
    int               wr_ptr;

    tag_result_t tag_result_q [$];
    tag_row_t    dir_rows [$];

    int cycle_cnt = 0;
    int n_errors = 0;
    int n_checked = 0;
    int burst_left = 0;
    int n_req [4] = '{0, 0, 0, 0};
    int n_alloc_stall = 0;
    int n_unmatched = 0;

    branch_tag_manager u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // receiver stall pattern, cycling through four modes
    always @(posedge clk)
    begin
        case ((cycle_cnt / 256) % 4)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 1) == 1);
            2:       m_tready <= ($urandom_range(0, 4) == 0);
            default: m_tready <= ((cycle_cnt % 7) < 3);
        endcase
    end

    function automatic void reset_tags(bit clear_ring);
        if (clear_ring)
        begin
            for (int i = 0; i < NTAGS; i++)
                alloc_ring[i] = '0;
            ring_valid = '0;
        end
        free_tags     = '1;
        free_tags[0]  = 1'b0;
        live          = '0;
        wr_ptr        = 1 % NTAGS;
        alloc_ring[0] = '0;
        ring_valid[0] = 1'b1;
    endfunction

    function automatic tag_result_t apply_tag_request(logic [1:0] req, logic [3:0] tag);
        tag_result_t      r;
        int               t;
        int               cur;
        int               pre;
        bit               hit;
        logic [NTAGS-1:0] freed;
        r     = '0;
        freed = '0;
        hit   = 1'b0;
        n_req[req]++;
        case (req)
            REQ_ALLOC:
            begin
                t = 0;
                while (t < NTAGS && !free_tags[t])
                    t++;
                if (t < NTAGS)
                begin
                    r.alloc_ok         = 1'b1;
                    live               = 4'(t);
                    free_tags[t]       = 1'b0;
                    alloc_ring[wr_ptr] = 4'(t);
                    ring_valid[wr_ptr] = 1'b1;
                    wr_ptr             = (wr_ptr + 1) % NTAGS;
                end
                else
                    n_alloc_stall++;
            end
            REQ_MISP:
            begin
                cur = (wr_ptr + NTAGS - 1) % NTAGS;
                for (int i = 0; i < NTAGS && !hit; i++)
                begin
                    pre = (cur + NTAGS - 1) % NTAGS;
                    r.kill_mask[alloc_ring[cur]] = 1'b1;
                    if (alloc_ring[pre] == tag)
                        hit = 1'b1;
                    else
                    begin
                        freed[alloc_ring[cur]] = 1'b1;
                        cur = pre;
                    end
                end
                if (hit)
                begin
                    free_tags = free_tags | freed;
                    live      = alloc_ring[cur];
                    wr_ptr    = (cur + 1) % NTAGS;
                end
                else
                begin
                    r.not_found = 1'b1;
                    n_unmatched++;
                end
            end
            REQ_COMMIT:
                free_tags[tag] = 1'b1;
            default:
                reset_tags(1'b0);
        endcase
        r.cur_tag = live;
        return r;
    endfunction

    function automatic void add_row(logic [1:0] req, logic [3:0] tag, bit typed = 1'b0,
                                    logic [3:0] cur = '0, logic ok = 1'b0,
                                    logic [KILL_W-1:0] kill = '0, logic nf = 1'b0);
        tag_row_t row;
        row.req = req;
        row.tag = tag;
        row.typed = typed;
        row.res = '{not_found: nf, kill_mask: kill, alloc_ok: ok, cur_tag: cur};
        dir_rows.push_back(row);
    endfunction

    task automatic idle_between(bit drain);
        int gap;
        if (drain)
        begin
            s_tvalid <= 1'b0;
            while (tag_result_q.size() != 0)
                @(posedge clk);
            @(posedge clk);
        end
        else
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
        end
    endtask

    task automatic issue_request(logic [1:0] req, logic [3:0] tag, bit typed,
                                 tag_result_t typed_res);
        tag_result_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, tag};
        s_tuser  <= req;
        do @(posedge clk); while (!s_tready);
        r = apply_tag_request(req, tag);
        tag_result_q.push_back(typed ? typed_res : r);
    endtask

    task automatic random_request(output logic [1:0] req, output logic [3:0] tag);
        int sel;
        int back;
        sel = $urandom_range(0, 99);
        tag = 4'($urandom_range(0, 15));
        if (sel < 40)
            req = REQ_ALLOC;
        else if (sel < 62)
        begin
            req = REQ_MISP;
            if ($urandom_range(0, 9) < 8)
            begin
                back = $urandom_range(1, 6);
                tag = alloc_ring[(wr_ptr + NTAGS - 1 - back) % NTAGS];
            end
        end
        else if (sel < 97)
            req = REQ_COMMIT;
        else
            req = REQ_FLUSH;
        // walk must never read a ring entry not yet written
        if (req == REQ_MISP && ring_valid != '1)
            req = REQ_ALLOC;
    endtask

    always @(posedge clk)
    begin
        tag_result_t got;
        tag_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = tag_result_t'(m_tdata[21:0]);
            if (tag_result_q.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected transfer: cur=%0d ok=%0b kill=%04h nf=%0b",
                             got.cur_tag, got.alloc_ok, got.kill_mask, got.not_found);
            end
            else
            begin
                want = tag_result_q.pop_front();
                n_checked++;
                if (got.cur_tag !== want.cur_tag || got.alloc_ok !== want.alloc_ok ||
                    got.kill_mask !== want.kill_mask || got.not_found !== want.not_found)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display({"mismatch on result %0d: exp cur=%0d ok=%0b kill=%04h ",
                                  "nf=%0b, got cur=%0d ok=%0b kill=%04h nf=%0b"},
                                 n_checked, want.cur_tag, want.alloc_ok, want.kill_mask,
                                 want.not_found, got.cur_tag, got.alloc_ok,
                                 got.kill_mask, got.not_found);
                end
            end
        end
    end

    initial
    begin
        while (cycle_cnt < LIMIT)
            @(posedge clk);
        $display("Timeout after %0d cycles", LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        logic [1:0] req;
        logic [3:0] tag;

        reset_tags(1'b1);

        add_row(REQ_COMMIT, 4'd15, 1'b1, 4'd0, 1'b0, '0, 1'b0);
        for (int i = 1; i < NTAGS; i++)
            add_row(REQ_ALLOC, 4'(i), 1'b1, 4'(i), 1'b1, '0, 1'b0);
        add_row(REQ_ALLOC, 4'd0, 1'b1, 4'd15, 1'b0, '0, 1'b0);  // no free tag
        add_row(REQ_MISP, 4'd14);
        add_row(REQ_MISP, 4'd9);
        add_row(REQ_COMMIT, 4'd3);
        add_row(REQ_ALLOC, 4'd0);
        add_row(REQ_MISP, 4'd11);                                // tag absent from ring
        add_row(REQ_COMMIT, 4'd0);
        add_row(REQ_FLUSH, 4'd7, 1'b1, 4'd0, 1'b0, '0, 1'b0);
        add_row(REQ_MISP, 4'd15);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            idle_between(1'b0);
            issue_request(dir_rows[i].req, dir_rows[i].tag, dir_rows[i].typed,
                          dir_rows[i].res);
        end

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            idle_between(i % 300 == 150);
            random_request(req, tag);
            issue_request(req, tag, 1'b0, '0);
        end

        idle_between(1'b1);
        repeat (DRAIN) @(posedge clk);

        $display({"Checked %0d transfers: %0d allocates (%0d with no free tag), ",
                  "%0d mispredicts (%0d unmatched),"},
                 n_checked, n_req[REQ_ALLOC], n_alloc_stall, n_req[REQ_MISP], n_unmatched);
        $display("%0d commits, %0d flushes, under random sender gaps and receiver stalls",
                 n_req[REQ_COMMIT], n_req[REQ_FLUSH]);
        if (n_errors == 0 && tag_result_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
